>>> rtl/core/ktd_pkg.sv
`default_nettype none

package ktd_pkg;

  // default build values
  localparam int KTD_NUM_KEYS  = 16;
  localparam int KTD_REPEAT_MS = 50;
  localparam int KTD_TIME_BITS = 32;

  // command queue depth between front and back
  localparam int CMD_DEPTH = 2;

  // stream payload widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DETECTOR_ON  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIPLE_WIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACTION_MAP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MASK  = 3'd5;

  // register reset values
  localparam logic        RST_DETECTOR_ON = 1'b1;
  localparam logic [15:0] RST_HOLD_MS     = 16'd500;
  localparam logic [15:0] RST_DOUBLE_WIN  = 16'd300;
  localparam logic [15:0] RST_TRIPLE_WIN  = 16'd300;

  // gesture codes, also the bit of each gesture in a key's action nibble
  localparam logic [1:0] G_QUICK  = 2'd0;
  localparam logic [1:0] G_HOLD   = 2'd1;
  localparam logic [1:0] G_DOUBLE = 2'd2;
  localparam logic [1:0] G_TRIPLE = 2'd3;

  // tap count that fires a triple press
  localparam logic [1:0] TRIPLE_TAPS = 2'd3;

  // action nibble of a key whose only gesture is quick
  localparam logic [3:0] NIB_QUICK_ONLY = 4'b0001;

  // one classified item on its way to the back end
  typedef struct packed {
    logic        is_tick;
    logic [3:0]  key;
    logic        is_press;
    logic [31:0] time_ms;
  } cmd_t;

  // settings seen by the back end
  typedef struct packed {
    logic [15:0] hold_ms;
    logic [15:0] double_window_ms;
    logic [15:0] triple_window_ms;
    logic [63:0] action_map;
    logic [15:0] repeat_mask;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/key_tap_hold_gesture_detector_unit.sv
`default_nettype none

// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: key_index, is_press, time_ms; tuser: func
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: out_key, gesture; tlast: last_of_run
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i (always ready)
//
// a key event works on its own key record only, a tick walks every record: the
// back end steps through the key records one per cycle unless a stalled output holds it, one key per step.
// a two-entry command queue lets the front take items while the back is busy.
// reset clears the control state of every key at once; timestamps are not
// read before they are written, so no sweep is needed.
// a stalled output holds the back end whenever a result must move on while
// the pending slot and the output register are both full.

module key_tap_hold_gesture_detector_unit
  import ktd_pkg::*;
#(
  parameter int NUM_KEYS  = KTD_NUM_KEYS,
  parameter int REPEAT_MS = KTD_REPEAT_MS,
  parameter int TIME_BITS = KTD_TIME_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [3:0] key_index, [4] is_press, [36:5] time_ms, [39:37] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] func
  input  wire logic                   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [3:0] out_key, [5:4] gesture, [7:6] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                        m_axis_tlast,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic detector_on_q;
  cfg_t cfg_q;
  logic cfg_we, clear;

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  logic [3:0] out_key;
  logic [1:0] out_gesture;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign clear       = cfg_we && (cfg_index_i == REG_DETECTOR_ON) && !cfg_data_i[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detector_on_q          <= RST_DETECTOR_ON;
      cfg_q.hold_ms          <= RST_HOLD_MS;
      cfg_q.double_window_ms <= RST_DOUBLE_WIN;
      cfg_q.triple_window_ms <= RST_TRIPLE_WIN;
      cfg_q.action_map       <= '0;
      cfg_q.repeat_mask      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_DETECTOR_ON: detector_on_q          <= cfg_data_i[0];
        REG_HOLD_MS:     cfg_q.hold_ms          <= cfg_data_i[15:0];
        REG_DOUBLE_WIN:  cfg_q.double_window_ms <= cfg_data_i[15:0];
        REG_TRIPLE_WIN:  cfg_q.triple_window_ms <= cfg_data_i[15:0];
        REG_ACTION_MAP:  cfg_q.action_map       <= cfg_data_i;
        REG_REPEAT_MASK: cfg_q.repeat_mask      <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // front: accept and classify
  ktd_front #(
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_data_i     (s_axis_tdata),
    .in_user_i     (s_axis_tuser),
    .detector_on_i (detector_on_q),
    .action_map_i  (cfg_q.action_map),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_cmd_o    (push_cmd)
  );

  // queue between front and back
  ktd_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // back: key record walk and result delivery
  ktd_back #(
    .NUM_KEYS  (NUM_KEYS),
    .REPEAT_MS (REPEAT_MS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (pop_valid),
    .cmd_ready_o   (pop_ready),
    .cmd_i         (pop_cmd),
    .cfg_i         (cfg_q),
    .clear_i       (clear),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_key_o     (out_key),
    .out_gesture_o (out_gesture),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_gesture, out_key};

endmodule

`default_nettype wire

>>> rtl/core/ktd_front.sv
`default_nettype none

module ktd_front
  import ktd_pkg::*;
#(
  parameter int NUM_KEYS = KTD_NUM_KEYS
) (
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [IN_TDATA_W-1:0] in_data_i,
  input  wire logic                  in_user_i,
  input  wire logic                  detector_on_i,
  input  wire logic [63:0]           action_map_i,
  output logic                       push_valid_o,
  input  wire logic                  push_ready_i,
  output cmd_t                       push_cmd_o
);

  localparam logic [4:0] KEY_LIMIT = 5'(NUM_KEYS);

  cmd_t       cmd;
  logic [3:0] nib;
  logic       drop;

  // unpack the transfer
  always_comb begin
    cmd.is_tick  = in_user_i;
    cmd.key      = in_data_i[3:0];
    cmd.is_press = in_data_i[4];
    cmd.time_ms  = in_data_i[36:5];
  end

  // events for a disabled block, an absent key or an unregistered key do nothing
  assign nib  = 4'(action_map_i >> {cmd.key, 2'b00});
  assign drop = !cmd.is_tick &&
                (!detector_on_i || ({1'b0, cmd.key} >= KEY_LIMIT) || (nib == 4'b0000));

  // dropped items are taken in at the pace of the queue all the same
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && !drop;
  assign push_cmd_o   = cmd;

endmodule

`default_nettype wire

>>> rtl/core/ktd_cmd_fifo.sv
`default_nettype none

module ktd_cmd_fifo
  import ktd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire cmd_t push_cmd_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output cmd_t      pop_cmd_o
);

  localparam int AW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CW = $clog2(CMD_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(CMD_DEPTH - 1);

  cmd_t          slot_q [CMD_DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign push_ready_o = (cnt_q != CW'(CMD_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = slot_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // pointer and fill bookkeeping
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LAST_SLOT) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LAST_SLOT) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ktd_back.sv
`default_nettype none

module ktd_back
  import ktd_pkg::*;
#(
  parameter int NUM_KEYS  = KTD_NUM_KEYS,
  parameter int REPEAT_MS = KTD_REPEAT_MS,
  parameter int TIME_BITS = KTD_TIME_BITS
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cmd_valid_i,
  output logic            cmd_ready_o,
  input  wire cmd_t       cmd_i,
  input  wire cfg_t       cfg_i,
  input  wire logic       clear_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [3:0]      out_key_o,
  output logic [1:0]      out_gesture_o,
  output logic            out_last_o
);

  localparam int TW = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [KW-1:0] LAST_KEY = KW'(NUM_KEYS - 1);
  localparam logic [15:0]   REP_LIM  = 16'(REPEAT_MS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_STEP  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  // per-key records
  logic          kd_q [NUM_KEYS];
  logic          ar_q [NUM_KEYS];
  logic [1:0]    tc_q [NUM_KEYS];
  logic [TW-1:0] pt_q [NUM_KEYS];
  logic [TW-1:0] rt_q [NUM_KEYS];

  logic [1:0]    state_q, state_d;
  logic [KW-1:0] walk_q, walk_d;
  cmd_t          cur_q, cur_d;

  // one result waits here until the next one shows whether it is the last
  logic          pend_v_q, pend_v_d;
  logic [3:0]    pend_key_q, pend_key_d;
  logic [1:0]    pend_g_q, pend_g_d;

  logic          out_v_q, out_v_d;
  logic [3:0]    out_key_q, out_key_d;
  logic [1:0]    out_g_q, out_g_d;
  logic          out_last_q, out_last_d;

  logic          kd, ar, kd_n, ar_n;
  logic [1:0]    tc, tc_n, tc_inc;
  logic [TW-1:0] pt, rt, pt_n, rt_n, now, start, diff;
  logic [15:0]   limit;
  logic [3:0]    nib;
  logic          rep_bit, rep_active, elapsed;
  logic          res_v;
  logic [1:0]    res_g;
  logic          out_free, step_fire;

  // read the record under the walk pointer
  always_comb begin
    kd      = kd_q[walk_q];
    ar      = ar_q[walk_q];
    tc      = tc_q[walk_q];
    pt      = pt_q[walk_q];
    rt      = rt_q[walk_q];
    nib     = 4'(cfg_i.action_map >> {6'(walk_q), 2'b00});
    rep_bit = cfg_i.repeat_mask[walk_q];
    now     = cur_q.time_ms[TW-1:0];
  end

  // one elapsed-time compare per step, its operands picked by the case at hand
  always_comb begin
    rep_active = kd && ar;
    if (!cur_q.is_tick) begin
      start = pt;
      limit = cfg_i.hold_ms;
    end else if (rep_active) begin
      start = pt;
      limit = REP_LIM;
    end else begin
      start = rt;
      limit = (tc == 2'd1) ? cfg_i.double_window_ms : cfg_i.triple_window_ms;
    end
    diff    = now - start;
    elapsed = (now >= start) && (diff >= TW'(limit));
  end

  // record update and gesture for one key
  always_comb begin
    kd_n   = kd;
    ar_n   = ar;
    tc_n   = tc;
    pt_n   = pt;
    rt_n   = rt;
    tc_inc = tc + 2'd1;
    res_v  = 1'b0;
    res_g  = G_QUICK;
    if (!cur_q.is_tick) begin
      if (cur_q.is_press) begin
        if (!kd) begin
          kd_n  = 1'b1;
          pt_n  = now;
          ar_n  = rep_bit && (nib == NIB_QUICK_ONLY);
          res_v = ar_n;
        end
      end else if (kd) begin
        kd_n = 1'b0;
        ar_n = 1'b0;
        if (nib[G_HOLD] && elapsed) begin
          res_v = 1'b1;
          res_g = G_HOLD;
          tc_n  = 2'd0;
        end else begin
          rt_n = now;
          if (tc_inc == TRIPLE_TAPS) begin
            res_v = nib[G_TRIPLE];
            res_g = G_TRIPLE;
            tc_n  = 2'd0;
          end else begin
            tc_n = tc_inc;
          end
        end
      end
    end else if (rep_active) begin
      if (elapsed) begin
        pt_n  = now;
        res_v = nib[G_QUICK];
      end
    end else if (!kd && (tc != 2'd0) && elapsed) begin
      res_g = (tc == 2'd1) ? G_QUICK : G_DOUBLE;
      res_v = nib[res_g];
      tc_n  = 2'd0;
    end
  end

  assign out_free    = !out_v_q || out_ready_i;
  assign cmd_ready_o = (state_q == ST_IDLE);
  assign step_fire   = (state_q == ST_STEP) && (!res_v || !pend_v_q || out_free);

  // sequencer, pending result and output register
  always_comb begin
    state_d    = state_q;
    walk_d     = walk_q;
    cur_d      = cur_q;
    pend_v_d   = pend_v_q;
    pend_key_d = pend_key_q;
    pend_g_d   = pend_g_q;
    out_v_d    = out_v_q && !out_ready_i;
    out_key_d  = out_key_q;
    out_g_d    = out_g_q;
    out_last_d = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cur_d   = cmd_i;
          walk_d  = cmd_i.is_tick ? '0 : cmd_i.key[KW-1:0];
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (step_fire) begin
          if (res_v) begin
            if (pend_v_q) begin
              out_v_d    = 1'b1;
              out_key_d  = pend_key_q;
              out_g_d    = pend_g_q;
              out_last_d = 1'b0;
            end
            pend_v_d   = 1'b1;
            pend_key_d = 4'(walk_q);
            pend_g_d   = res_g;
          end
          if (!cur_q.is_tick || (walk_q == LAST_KEY)) begin
            state_d = ST_FLUSH;
          end else begin
            walk_d = walk_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_v_d    = 1'b1;
          out_key_d  = pend_key_q;
          out_g_d    = pend_g_q;
          out_last_d = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      walk_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      walk_q   <= walk_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    pend_key_q <= pend_key_d;
    pend_g_q   <= pend_g_d;
    out_key_q  <= out_key_d;
    out_g_q    <= out_g_d;
    out_last_q <= out_last_d;
  end

  // key control state, cleared together when detection is switched off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        kd_q[i] <= 1'b0;
        ar_q[i] <= 1'b0;
        tc_q[i] <= 2'd0;
      end
    end else if (clear_i) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        kd_q[i] <= 1'b0;
        ar_q[i] <= 1'b0;
        tc_q[i] <= 2'd0;
      end
    end else if (step_fire) begin
      kd_q[walk_q] <= kd_n;
      ar_q[walk_q] <= ar_n;
      tc_q[walk_q] <= tc_n;
    end
  end

  // timestamps are only read once the control state says they were written
  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      pt_q[walk_q] <= pt_n;
      rt_q[walk_q] <= rt_n;
    end
  end

  assign out_valid_o   = out_v_q;
  assign out_key_o     = out_key_q;
  assign out_gesture_o = out_g_q;
  assign out_last_o    = out_last_q;

`ifndef SYNTHESIS
  // every run is closed before the sequencer goes idle
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("result left pending while idle");

  // a taken command always starts a walk
  a_pop_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && cmd_ready_o) |=> (state_q == ST_STEP))
    else $error("command taken without a step");

  // the walk never leaves the key range
  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (walk_q <= LAST_KEY))
    else $error("walk pointer out of range");

  // an event works on its own key only
  a_event_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP && !cur_q.is_tick) |-> (walk_q == cur_q.key[KW-1:0]))
    else $error("event step on wrong key");
`endif

endmodule

`default_nettype wire
